@@ design/icl_pkg.sv @@
// Package for the inode cache engine: slot record, link word, beat types,
// command and status codes, controller states. No dependencies.
`default_nettype none
package icl_pkg;

  localparam int SLOTS  = 128;
  localparam int SLOT_W = 7;
  localparam int CNT_W  = 8;
  localparam int TAG_W  = 16;
  localparam logic [TAG_W-1:0] COUNT_MAX = 16'hFFFF;

  localparam logic [1:0] CMD_GET    = 2'd0;
  localparam logic [1:0] CMD_PUT    = 2'd1;
  localparam logic [1:0] CMD_DIRTY  = 2'd2;
  localparam logic [1:0] CMD_ACTIVE = 2'd3;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_BUSY  = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_BAD   = 3'd3;
  localparam logic [2:0] ST_REFER = 3'd4;
  localparam logic [2:0] ST_SAT   = 3'd5;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [TAG_W-1:0]  device;
    logic [TAG_W-1:0]  inode_number;
    logic [SLOT_W-1:0] slot_in;
    logic              link_count_zero;
  } icl_req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot_out;
    logic              need_disk_read;
    logic              need_truncate_free;
    logic              need_writeback;
    logic              active_found;
  } icl_rsp_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag_device;
    logic [TAG_W-1:0] tag_inode;
    logic [TAG_W-1:0] ref_count;
    logic             lock_bit;
    logic             dirty_bit;
  } icl_rec_t;

  typedef struct packed {
    logic              re;
    logic [SLOT_W-1:0] raddr;
    logic              we;
    logic [SLOT_W-1:0] waddr;
    icl_rec_t          wdata;
  } icl_rec_port_t;

  typedef struct packed {
    logic [SLOT_W-1:0] nxt;
    logic [SLOT_W-1:0] prv;
  } icl_lnk_t;

  typedef struct packed {
    logic              re;
    logic [SLOT_W-1:0] raddr;
    logic              we_next;
    logic              we_prev;
    logic [SLOT_W-1:0] waddr;
    logic [SLOT_W-1:0] wdata;
  } icl_lnk_port_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_GET_EV, S_MISS_EV, S_UNL_RD, S_UNL_EV, S_UNL_B,
    S_REC_RD, S_REC_EV, S_APP_A, S_APP_B, S_DONE
  } icl_state_t;

endpackage
`default_nettype wire

@@ design/icl_rec_ram.sv @@
// Slot record memory: tags, reference count, lock and dirty per slot.
// Depends on icl_pkg. Entries never written read as all zero.
`default_nettype none
module icl_rec_ram (
  input  wire                   clk,
  input  wire                   rst,
  input  icl_pkg::icl_rec_port_t port,
  output icl_pkg::icl_rec_t     rdata
);
  import icl_pkg::*;

  logic [SLOTS-1:0] vld;
  icl_rec_t         mem [SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (port.we) begin
      vld[port.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (port.we) begin
      mem[port.waddr] <= port.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (port.re) begin
      rdata <= vld[port.raddr] ? mem[port.raddr] : '0;
    end
  end

endmodule
`default_nettype wire

@@ design/icl_link_ram.sv @@
// Free-list link memory: next and prev per slot, written one field at a time.
// Depends on icl_pkg. Unwritten entries read as the reset chain.
`default_nettype none
module icl_link_ram (
  input  wire                   clk,
  input  wire                   rst,
  input  icl_pkg::icl_lnk_port_t port,
  output icl_pkg::icl_lnk_t     rdata
);
  import icl_pkg::*;

  logic [SLOTS-1:0] vld;
  icl_lnk_t         mem [SLOTS];

  function automatic logic [SLOT_W-1:0] init_next(input logic [SLOT_W-1:0] i);
    init_next = (i == '0) ? '0 : i - 1'b1;
  endfunction

  function automatic logic [SLOT_W-1:0] init_prev(input logic [SLOT_W-1:0] i);
    init_prev = (i == SLOT_W'(SLOTS - 1)) ? '0 : i + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (port.we_next || port.we_prev) begin
      vld[port.waddr] <= 1'b1;
    end
  end

  // untouched field of a first write takes its reset value
  always_ff @(posedge clk) begin
    if (port.we_next || port.we_prev) begin
      if (port.we_next) begin
        mem[port.waddr].nxt <= port.wdata;
      end else if (!vld[port.waddr]) begin
        mem[port.waddr].nxt <= init_next(port.waddr);
      end
      if (port.we_prev) begin
        mem[port.waddr].prv <= port.wdata;
      end else if (!vld[port.waddr]) begin
        mem[port.waddr].prv <= init_prev(port.waddr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (port.re) begin
      if (vld[port.raddr]) begin
        rdata <= mem[port.raddr];
      end else begin
        rdata.nxt <= init_next(port.raddr);
        rdata.prv <= init_prev(port.raddr);
      end
    end
  end

endmodule
`default_nettype wire

@@ design/icl_ctrl.sv @@
// Command sequencer: slot scan, record update, free-list unlink and append.
// Depends on icl_pkg; drives the record and link memory ports.
`default_nettype none
module icl_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    req_valid,
  output logic                   req_stall,
  input  icl_pkg::icl_req_t      req,
  input  wire                    res_free,
  output logic                   done,
  output icl_pkg::icl_rsp_t      res,
  output icl_pkg::icl_rec_port_t rec_port,
  input  icl_pkg::icl_rec_t      rec_rd,
  output icl_pkg::icl_lnk_port_t lnk_port,
  input  icl_pkg::icl_lnk_t      lnk_rd
);
  import icl_pkg::*;

  icl_state_t        state, state_next;
  icl_req_t          cur, cur_next;
  icl_rsp_t          res_next;
  logic [CNT_W-1:0]  scan_idx, scan_idx_next;
  logic              pend, pend_next;
  logic [SLOT_W-1:0] chk, chk_next;
  logic [SLOT_W-1:0] sel, sel_next;
  logic [SLOT_W-1:0] head, head_next;
  logic [SLOT_W-1:0] tail, tail_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              g_match, a_match;
  logic [TAG_W-1:0]  ref_dec;
  logic              put_zero, put_dirty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= SLOT_W'(SLOTS - 1);
      tail  <= '0;
      count <= CNT_W'(SLOTS);
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    res      <= res_next;
    scan_idx <= scan_idx_next;
    chk      <= chk_next;
    sel      <= sel_next;
  end

  assign g_match = (rec_rd.tag_inode != '0) && (rec_rd.tag_inode == cur.inode_number) &&
                   (rec_rd.tag_device == cur.device);
  assign a_match = (rec_rd.ref_count != '0) && (rec_rd.tag_device == cur.device) &&
                   (rec_rd.tag_inode != TAG_W'(1));
  assign ref_dec   = rec_rd.ref_count - 1'b1;
  assign put_zero  = (ref_dec == '0);
  assign put_dirty = rec_rd.dirty_bit || (put_zero && cur.link_count_zero);

  always_comb begin
    state_next    = state;
    cur_next      = cur;
    res_next      = res;
    scan_idx_next = scan_idx;
    pend_next     = pend;
    chk_next      = chk;
    sel_next      = sel;
    head_next     = head;
    tail_next     = tail;
    count_next    = count;
    rec_port      = '0;
    lnk_port      = '0;
    done          = 1'b0;
    req_stall     = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cur_next      = req;
          res_next      = '0;
          scan_idx_next = '0;
          pend_next     = 1'b0;
          case (req.cmd)
            CMD_GET: begin
              if (req.inode_number == '0) begin
                res_next.status = ST_BAD;
                state_next      = S_DONE;
              end else begin
                state_next = S_SCAN;
              end
            end
            CMD_ACTIVE: state_next = S_SCAN;
            default: begin
              if ({1'b0, req.slot_in} >= CNT_W'(SLOTS)) begin
                res_next.status = ST_BAD;
                state_next      = S_DONE;
              end else begin
                state_next = S_REC_RD;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        if (pend && ((cur.cmd == CMD_GET) ? g_match : a_match)) begin
          if (cur.cmd == CMD_GET) begin
            sel_next   = chk;
            state_next = S_GET_EV;
          end else begin
            res_next.active_found = 1'b1;
            state_next            = S_DONE;
          end
        end else if (scan_idx == CNT_W'(SLOTS)) begin
          state_next = (cur.cmd == CMD_GET) ? S_MISS_EV : S_DONE;
        end else begin
          rec_port.re    = 1'b1;
          rec_port.raddr = scan_idx[SLOT_W-1:0];
          chk_next       = scan_idx[SLOT_W-1:0];
          scan_idx_next  = scan_idx + 1'b1;
          pend_next      = 1'b1;
        end
      end
      S_GET_EV: begin
        if (rec_rd.lock_bit) begin
          res_next.status = ST_BUSY;
          state_next      = S_DONE;
        end else if (rec_rd.ref_count == COUNT_MAX) begin
          res_next.status = ST_SAT;
          state_next      = S_DONE;
        end else begin
          rec_port.we                = 1'b1;
          rec_port.waddr             = sel;
          rec_port.wdata             = rec_rd;
          rec_port.wdata.ref_count   = rec_rd.ref_count + 1'b1;
          rec_port.wdata.lock_bit    = 1'b1;
          res_next.slot_out          = sel;
          state_next = (rec_rd.ref_count == '0) ? S_UNL_RD : S_DONE;
        end
      end
      S_MISS_EV: begin
        if (count == '0) begin
          res_next.status = ST_FULL;
          state_next      = S_DONE;
        end else begin
          sel_next                 = head;
          rec_port.we              = 1'b1;
          rec_port.waddr           = head;
          rec_port.wdata           = '0;
          rec_port.wdata.tag_device = cur.device;
          rec_port.wdata.tag_inode = cur.inode_number;
          rec_port.wdata.ref_count = TAG_W'(1);
          rec_port.wdata.lock_bit  = 1'b1;
          res_next.slot_out        = head;
          res_next.need_disk_read  = 1'b1;
          state_next               = S_UNL_RD;
        end
      end
      S_UNL_RD: begin
        if (count == '0) begin
          state_next = S_DONE;
        end else if (count == CNT_W'(1)) begin
          count_next = '0;
          state_next = S_DONE;
        end else begin
          lnk_port.re    = 1'b1;
          lnk_port.raddr = sel;
          state_next     = S_UNL_EV;
        end
      end
      S_UNL_EV: begin
        if (sel == head) begin
          head_next = lnk_rd.nxt;
        end else begin
          lnk_port.we_next = 1'b1;
          lnk_port.waddr   = lnk_rd.prv;
          lnk_port.wdata   = lnk_rd.nxt;
        end
        state_next = S_UNL_B;
      end
      S_UNL_B: begin
        if (sel == tail) begin
          tail_next = lnk_rd.prv;
        end else begin
          lnk_port.we_prev = 1'b1;
          lnk_port.waddr   = lnk_rd.nxt;
          lnk_port.wdata   = lnk_rd.prv;
        end
        count_next = count - 1'b1;
        state_next = S_DONE;
      end
      S_REC_RD: begin
        rec_port.re    = 1'b1;
        rec_port.raddr = cur.slot_in;
        sel_next       = cur.slot_in;
        state_next     = S_REC_EV;
      end
      S_REC_EV: begin
        if (cur.cmd == CMD_DIRTY) begin
          rec_port.we              = 1'b1;
          rec_port.waddr           = sel;
          rec_port.wdata           = rec_rd;
          rec_port.wdata.dirty_bit = 1'b1;
          state_next               = S_DONE;
        end else if (rec_rd.ref_count == '0) begin
          res_next.status = ST_REFER;
          state_next      = S_DONE;
        end else begin
          rec_port.we                 = 1'b1;
          rec_port.waddr              = sel;
          rec_port.wdata              = rec_rd;
          rec_port.wdata.ref_count    = ref_dec;
          rec_port.wdata.lock_bit     = 1'b0;
          rec_port.wdata.dirty_bit    = 1'b0;
          res_next.need_truncate_free = put_zero && cur.link_count_zero;
          res_next.need_writeback     = put_dirty;
          state_next = put_zero ? S_APP_A : S_DONE;
        end
      end
      S_APP_A: begin
        if (count == '0) begin
          head_next  = sel;
          tail_next  = sel;
          count_next = count + 1'b1;
          state_next = S_DONE;
        end else begin
          lnk_port.we_next = 1'b1;
          lnk_port.waddr   = tail;
          lnk_port.wdata   = sel;
          state_next       = S_APP_B;
        end
      end
      S_APP_B: begin
        lnk_port.we_prev = 1'b1;
        lnk_port.waddr   = sel;
        lnk_port.wdata   = tail;
        tail_next        = sel;
        count_next       = count + 1'b1;
        state_next       = S_DONE;
      end
      S_DONE: begin
        done = 1'b1;
        if (res_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(SLOTS))
    else $error("free count above slot total");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !rec_port.we && !lnk_port.we_next && !lnk_port.we_prev)
    else $error("memory write while idle");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> res.status <= ST_SAT)
    else $error("undefined status code");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_UNL_B) |=> count == $past(count) - 1'b1)
    else $error("unlink did not drop free count");

endmodule
`default_nettype wire

@@ design/inode_cache_lru_engine_top.sv @@
// Top level of the inode cache engine: controller, two memories, result register.
// Depends on icl_pkg, icl_ctrl, icl_rec_ram, icl_link_ram.
//
//   channel | signals                      | beat
//   --------+------------------------------+----------------------------------
//   request | req_valid, req_stall, req    | one command: get/put/dirty/query
//   result  | rsp_valid, rsp_stall, rsp    | one status beat per command
//
// One command at a time. Get scans the record memory one slot per cycle from
// slot 0 and stops at the first hit; a miss scans every slot. Active query
// scans the same way; put and mark dirty skip the scan and read the named
// slot directly. The scan runs over the single read port of the record memory.
// Reset is synchronous; memories need no clearing pass (per-entry valid bits).
// A finished beat sits in the result register; the next command is taken
// while it waits, and only its own completion waits for rsp_stall to drop.
`default_nettype none
module inode_cache_lru_engine_top (
  input  wire               clk,
  input  wire               rst,
  input  wire               req_valid,
  output logic              req_stall,
  input  icl_pkg::icl_req_t req,
  output logic              rsp_valid,
  input  wire               rsp_stall,
  output icl_pkg::icl_rsp_t rsp
);
  import icl_pkg::*;

  icl_rec_port_t rec_port;
  icl_rec_t      rec_rd;
  icl_lnk_port_t lnk_port;
  icl_lnk_t      lnk_rd;
  icl_rsp_t      res;
  logic          done;
  logic          res_free;

  // result register may load when empty or being drained this cycle
  assign res_free = !rsp_valid || !rsp_stall;

  icl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .res_free (res_free),
    .done     (done),
    .res      (res),
    .rec_port (rec_port),
    .rec_rd   (rec_rd),
    .lnk_port (lnk_port),
    .lnk_rd   (lnk_rd)
  );

  icl_rec_ram u_rec (
    .clk  (clk),
    .rst  (rst),
    .port (rec_port),
    .rdata(rec_rd)
  );

  icl_link_ram u_lnk (
    .clk  (clk),
    .rst  (rst),
    .port (lnk_port),
    .rdata(lnk_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done && res_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && res_free) begin
      rsp <= res;
    end
  end

endmodule
`default_nettype wire
